FILE: src/ilp_pkg.sv
// Shared types and constants for the integer literal parser.
package ilp_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 3;
    localparam int MAG_W   = 33;
    localparam int DIGIT_W = 4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK              = 3'd0;
    localparam logic [STAT_W-1:0] ST_MINUS_MISPLACED = 3'd1;
    localparam logic [STAT_W-1:0] ST_MINUS_ALONE     = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_DIGIT       = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_PREFIX      = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY           = 3'd5;
    localparam logic [STAT_W-1:0] ST_OVERFLOW        = 3'd6;

    // Character class flags from the decoder
    typedef struct packed {
        logic               is_minus;
        logic               is_lit;    // hex digit, x or X
        logic               is_zero;
        logic               is_dec;
        logic               is_hex;
        logic               is_b;
        logic               is_x;
        logic [DIGIT_W-1:0] digit;
    } ilp_char_t;

    // One result from the parser core
    typedef struct packed {
        logic                emit;
        logic [VALUE_W-1:0]  value;
        logic [STAT_W-1:0]   status;
    } ilp_result_t;

endpackage

FILE: src/integer_literal_parser.sv
// Integer literal parser: one character per beat in, one value and status per literal out.
// Takes one character per beat and can accept a new one every clock cycle. A
// character is first captured in an input register; once the result slot is free, the core
// updates sign, base and running magnitude (one shift-and-add by the base, held
// at 2^32) and, on a terminator or a misplaced minus, loads the result register.
// A result beat is loaded into the output register when the core steps on the
// character that ends the literal. The stream stalls only while a result waits
// in the output register and out_ready is low. Status codes: 0 ok, 1 misplaced
// minus, 2 minus without digits, 3 bad digit, 4 bad prefix, 5 empty, 6 overflow;
// value is zero unless status is ok.
module integer_literal_parser
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ilp_pkg::CHAR_W-1:0]         char_code,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ilp_pkg::VALUE_W-1:0] value,
    output logic [ilp_pkg::STAT_W-1:0]         status
);

    logic                          s1_valid_reg, s1_valid_next;
    logic [ilp_pkg::CHAR_W-1:0]    char_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [ilp_pkg::VALUE_W-1:0]   value_reg;
    logic [ilp_pkg::STAT_W-1:0]    status_reg;
    logic                          step;
    ilp_pkg::ilp_char_t            cls;
    ilp_pkg::ilp_result_t          res;

    // Advance the held character when the result slot is free or being drained
    assign step          = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready      = !s1_valid_reg || step;
    assign s1_valid_next = in_valid ? 1'b1 : (s1_valid_reg && !step);

    always_comb
    begin
        if (step)
        begin
            out_valid_next = res.emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    ilp_decode u_decode
    (
        .char_code (char_reg),
        .cls       (cls)
    );

    ilp_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cls   (cls),
        .res   (res)
    );

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture input character and result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
        end
        if (step && res.emit)
        begin
            value_reg  <= res.value;
            status_reg <= res.status;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule

FILE: src/ilp_decode.sv
// Character classifier: sorts one ASCII code into literal classes.
module ilp_decode
(
    input  logic [ilp_pkg::CHAR_W-1:0] char_code,
    output ilp_pkg::ilp_char_t         cls
);

    localparam logic [ilp_pkg::CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [ilp_pkg::CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [ilp_pkg::CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [ilp_pkg::CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [ilp_pkg::CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [ilp_pkg::CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [ilp_pkg::CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [ilp_pkg::CHAR_W-1:0] CH_LB    = 8'h62;
    localparam logic [ilp_pkg::CHAR_W-1:0] CH_UB    = 8'h42;
    localparam logic [ilp_pkg::CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [ilp_pkg::CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [ilp_pkg::CHAR_W-1:0] TEN      = 8'd10;

    logic                        dec;
    logic                        lower;
    logic                        upper;
    logic [ilp_pkg::CHAR_W-1:0]  off;

    // Classify ranges
    always_comb
    begin
        dec   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        lower = (char_code >= CH_LA) && (char_code <= CH_LF);
        upper = (char_code >= CH_UA) && (char_code <= CH_UF);
        if (dec)
        begin
            off = char_code - CH_ZERO;
        end
        else if (lower)
        begin
            off = char_code - CH_LA + TEN;
        end
        else
        begin
            off = char_code - CH_UA + TEN;
        end

        cls.is_minus = (char_code == CH_MINUS);
        cls.is_dec   = dec;
        cls.is_hex   = dec | lower | upper;
        cls.is_zero  = (char_code == CH_ZERO);
        cls.is_b     = (char_code == CH_LB) || (char_code == CH_UB);
        cls.is_x     = (char_code == CH_LX) || (char_code == CH_UX);
        cls.is_lit   = cls.is_hex | cls.is_x;
        cls.digit    = off[ilp_pkg::DIGIT_W-1:0];
    end

endmodule

FILE: src/ilp_core.sv
// Parser core: phase, sign, base, magnitude and pending error per character.
module ilp_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  ilp_pkg::ilp_char_t   cls,
    output ilp_pkg::ilp_result_t res
);

    typedef enum logic [1:0]
    {
        PH_NONE  = 2'd0,
        PH_MINUS = 2'd1,
        PH_ZERO  = 2'd2,
        PH_BODY  = 2'd3
    } phase_t;

    typedef enum logic [1:0]
    {
        BASE_DEC = 2'd0,
        BASE_BIN = 2'd1,
        BASE_HEX = 2'd2
    } base_t;

    localparam int ACC_W = ilp_pkg::MAG_W + 4;
    localparam logic [ilp_pkg::MAG_W-1:0] MAG_CAP   = 33'h1_0000_0000;
    localparam logic [ilp_pkg::MAG_W-1:0] LIMIT_POS = 33'h0_7FFF_FFFF;
    localparam logic [ilp_pkg::MAG_W-1:0] LIMIT_NEG = 33'h0_8000_0000;

    phase_t                       phase_reg, phase_next;
    base_t                        base_reg, base_next;
    base_t                        eff_base;
    logic                         neg_reg, neg_next;
    logic [ilp_pkg::MAG_W-1:0]    mag_reg, mag_next;
    logic [ilp_pkg::STAT_W-1:0]   err_reg, err_next;

    logic [ACC_W-1:0]             mag_ext;
    logic [ACC_W-1:0]             prod;
    logic [ACC_W-1:0]             sum;
    logic [ilp_pkg::MAG_W-1:0]    acc;
    logic                         digit_ok;
    logic [ilp_pkg::MAG_W-1:0]    limit;
    logic [ilp_pkg::VALUE_W-1:0]  mag32;

    // Scale the magnitude by the base and add the digit, saturating at the cap
    always_comb
    begin
        eff_base = ((phase_reg == PH_NONE) || (phase_reg == PH_MINUS)) ? BASE_DEC : base_reg;
        mag_ext  = {4'd0, mag_reg};
        case (eff_base)
            BASE_BIN:
            begin
                prod     = mag_ext << 1;
                digit_ok = cls.is_dec && (cls.digit <= 4'd1);
            end
            BASE_HEX:
            begin
                prod     = mag_ext << 4;
                digit_ok = cls.is_hex;
            end
            default:
            begin
                prod     = (mag_ext << 3) + (mag_ext << 1);
                digit_ok = cls.is_dec;
            end
        endcase
        sum = prod + {{(ACC_W-ilp_pkg::DIGIT_W){1'b0}}, cls.digit};
        acc = (sum > {4'd0, MAG_CAP}) ? MAG_CAP : sum[ilp_pkg::MAG_W-1:0];
    end

    // Work out the next state and any result for this character
    always_comb
    begin
        phase_next = phase_reg;
        base_next  = base_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        err_next   = err_reg;
        res.emit   = 1'b0;
        res.value  = '0;
        res.status = ilp_pkg::ST_OK;
        limit      = neg_reg ? LIMIT_NEG : LIMIT_POS;
        mag32      = mag_reg[ilp_pkg::VALUE_W-1:0];

        if (cls.is_minus)
        begin
            if (phase_reg == PH_NONE)
            begin
                neg_next   = 1'b1;
                phase_next = PH_MINUS;
            end
            else
            begin
                res.emit   = 1'b1;
                res.status = ilp_pkg::ST_MINUS_MISPLACED;
            end
        end
        else if (cls.is_lit)
        begin
            case (phase_reg)
                PH_NONE, PH_MINUS:
                begin
                    if (cls.is_zero)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                        base_next  = BASE_DEC;
                        if (!digit_ok)
                        begin
                            err_next = ilp_pkg::ST_BAD_DIGIT;
                        end
                        else
                        begin
                            mag_next = acc;
                        end
                    end
                end
                PH_ZERO:
                begin
                    phase_next = PH_BODY;
                    if (cls.is_dec)
                    begin
                        base_next = BASE_DEC;
                        mag_next  = acc;
                    end
                    else if (cls.is_b)
                    begin
                        base_next = BASE_BIN;
                    end
                    else if (cls.is_x)
                    begin
                        base_next = BASE_HEX;
                    end
                    else
                    begin
                        err_next = ilp_pkg::ST_BAD_PREFIX;
                    end
                end
                default:
                begin
                    if (err_reg == ilp_pkg::ST_OK)
                    begin
                        if (!digit_ok)
                        begin
                            err_next = ilp_pkg::ST_BAD_DIGIT;
                        end
                        else
                        begin
                            mag_next = acc;
                        end
                    end
                end
            endcase
        end
        else
        begin
            // Terminator: report the literal
            res.emit = 1'b1;
            if (phase_reg == PH_NONE)
            begin
                res.status = ilp_pkg::ST_EMPTY;
            end
            else if (phase_reg == PH_MINUS)
            begin
                res.status = ilp_pkg::ST_MINUS_ALONE;
            end
            else if (err_reg != ilp_pkg::ST_OK)
            begin
                res.status = err_reg;
            end
            else if (mag_reg > limit)
            begin
                res.status = ilp_pkg::ST_OVERFLOW;
            end
            else
            begin
                res.value = neg_reg ? (~mag32 + 32'd1) : mag32;
            end
        end

        // Clear all state after a result
        if (res.emit)
        begin
            phase_next = PH_NONE;
            base_next  = BASE_DEC;
            neg_next   = 1'b0;
            mag_next   = '0;
            err_next   = ilp_pkg::ST_OK;
        end
    end

    // Hold parser state; advance on each character step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NONE;
            base_reg  <= BASE_DEC;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            err_reg   <= ilp_pkg::ST_OK;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            err_reg   <= err_next;
        end
    end

endmodule

FILE: src/ilp_checker.sv
// Port-level checks for the integer literal parser, bound to the top level.
module ilp_port_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [ilp_pkg::VALUE_W-1:0] value,
    input logic [ilp_pkg::STAT_W-1:0]         status
);

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(value) && $stable(status))
        else $error("result payload changed while stalled");

    // Error results carry a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ilp_pkg::ST_OK) |-> (value == '0))
        else $error("nonzero value with error status");

    // Status stays within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ilp_pkg::ST_OVERFLOW))
        else $error("undefined status code");

    // Input side never stalls while the output is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(out_valid) |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind integer_literal_parser ilp_port_checker u_ilp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
);
